/* src/tbd_pkg.sv */
// ----------------------------------------------------------------------------
// tbd_pkg
// Shared types and constants of the track bitstream byte decoder.
// ----------------------------------------------------------------------------
package tbd_pkg;

  // decode modes
  localparam logic [1:0] ModeRaw  = 2'd0;
  localparam logic [1:0] ModeGcr  = 2'd1;
  localparam logic [1:0] ModeMfm  = 2'd2;
  localparam logic [1:0] ModeNone = 2'd3;

  // register indexes, taken from paddr[2]
  localparam logic RegDecodeMode  = 1'b0;
  localparam logic RegSyncPattern = 1'b1;

  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  localparam logic [1:0]  ModeReset   = ModeMfm;
  localparam logic [15:0] SyncDefault = 16'h4489;
  localparam logic [15:0] PhaseSync   = 16'haaaa;
  localparam logic [15:0] PhaseReset  = 16'hffff;

  typedef struct packed {
    logic [1:0]  decode_mode;
    logic [15:0] sync_pattern;
  } cfg_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] data_byte;
    logic       short_byte;
  } result_t;

endpackage

/* src/tbd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tbd_cfg_regs
// APB-style register file holding the decode mode and the MFM sync word.
// ----------------------------------------------------------------------------
module tbd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbd_pkg::AddrWidth-1:0] paddr,
  input  logic [tbd_pkg::DataWidth-1:0] pwdata,
  output logic [tbd_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  output tbd_pkg::cfg_t                 cfg_o
);
  import tbd_pkg::*;

  logic [1:0]  mode_q, mode_d;
  logic [15:0] sync_q, sync_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    mode_d = mode_q;
    sync_d = sync_q;
    if (wr_en) begin
      unique case (paddr[2])
        RegDecodeMode:  mode_d = pwdata[1:0];
        RegSyncPattern: sync_d = pwdata[15:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegDecodeMode:  prdata = {{(DataWidth-2){1'b0}}, mode_q};
      RegSyncPattern: prdata = {{(DataWidth-16){1'b0}}, sync_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
      sync_q <= SyncDefault;
    end else begin
      mode_q <= mode_d;
      sync_q <= sync_d;
    end
  end

  assign cfg_o.decode_mode  = mode_q;
  assign cfg_o.sync_pattern = sync_q;

endmodule

/* src/tbd_decode_core.sv */
// ----------------------------------------------------------------------------
// tbd_decode_core
// Decode state registers and the combinational step logic for raw, GCR and
// MFM modes.
// ----------------------------------------------------------------------------
module tbd_decode_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             track_bit_i,
  input  logic             track_last_i,
  input  tbd_pkg::cfg_t    cfg_i,
  output tbd_pkg::result_t result_o
);
  import tbd_pkg::*;

  logic [15:0] cell_shift_q, cell_shift_d;
  logic [15:0] clock_phase_q, clock_phase_d;
  logic [7:0]  byte_accum_q, byte_accum_d;
  logic [3:0]  bit_count_q, bit_count_d;

  // left-align a partial byte holding cnt bits (cnt in 1..7)
  function automatic logic [7:0] left_align(logic [7:0] acc, logic [3:0] cnt);
    logic [2:0] pad;
    pad = 3'(4'd8 - cnt);
    return acc << pad;
  endfunction

  always_comb begin
    cell_shift_d        = cell_shift_q;
    clock_phase_d       = clock_phase_q;
    byte_accum_d        = byte_accum_q;
    bit_count_d         = bit_count_q;
    result_o.emit       = 1'b0;
    result_o.data_byte  = '0;
    result_o.short_byte = 1'b0;

    unique case (cfg_i.decode_mode)
      ModeRaw: begin
        byte_accum_d = {byte_accum_q[6:0], track_bit_i};
        bit_count_d  = bit_count_q + 4'd1;
        if (bit_count_d >= 4'd8) begin
          result_o.emit      = 1'b1;
          result_o.data_byte = byte_accum_d;
          byte_accum_d       = '0;
          bit_count_d        = '0;
        end else if (track_last_i) begin
          result_o.emit       = 1'b1;
          result_o.data_byte  = left_align(byte_accum_d, bit_count_d);
          result_o.short_byte = 1'b1;
        end
      end
      ModeGcr: begin
        byte_accum_d = {byte_accum_q[6:0], track_bit_i};
        if (byte_accum_d[7]) begin
          result_o.emit      = 1'b1;
          result_o.data_byte = byte_accum_d;
          byte_accum_d       = '0;
        end
      end
      ModeMfm: begin
        cell_shift_d  = {cell_shift_q[14:0], track_bit_i};
        clock_phase_d = {clock_phase_q[14:0], ~clock_phase_q[0]};
        if (cell_shift_d == cfg_i.sync_pattern) begin
          if (bit_count_q != 4'd0) begin
            result_o.emit       = 1'b1;
            result_o.data_byte  = left_align(byte_accum_q, {1'b0, bit_count_q[2:0]});
            result_o.short_byte = 1'b1;
            byte_accum_d        = '0;
            bit_count_d         = '0;
          end
          clock_phase_d = PhaseSync;
        end
        // data cell: phase top bit low (never right after a sync hit)
        if (!clock_phase_d[15]) begin
          byte_accum_d = {byte_accum_d[6:0], cell_shift_d[15]};
          bit_count_d  = bit_count_d + 4'd1;
          if (bit_count_d >= 4'd8) begin
            result_o.emit      = 1'b1;
            result_o.data_byte = byte_accum_d;
            byte_accum_d       = '0;
            bit_count_d        = '0;
          end
        end
      end
      ModeNone: ;
      default: ;
    endcase

    if (track_last_i) begin
      cell_shift_d  = '0;
      clock_phase_d = PhaseReset;
      byte_accum_d  = '0;
      bit_count_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_shift_q  <= '0;
      clock_phase_q <= PhaseReset;
      byte_accum_q  <= '0;
      bit_count_q   <= '0;
    end else if (step_i) begin
      cell_shift_q  <= cell_shift_d;
      clock_phase_q <= clock_phase_d;
      byte_accum_q  <= byte_accum_d;
      bit_count_q   <= bit_count_d;
    end
  end

endmodule

/* src/track_bitstream_byte_decoder.sv */
// ----------------------------------------------------------------------------
// track_bitstream_byte_decoder
// Turns a stream of track cell bits into bytes by raw packing, GCR byte
// assembly or MFM data separation with sync realignment.
//
//   channel  direction  handshake                   payload
//   track    in         track_valid_i/track_stall_o track_bit_i, track_last_i
//   byte     out        byte_valid_o/byte_stall_i   data_byte_o, short_byte_o
//   config   in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// One track bit is taken every cycle while track_stall_o is low; its byte, if
// any, passes through the input register, then the result register.
// The decode state advances in the single step from input to result register.
// Reset clears the decode state and loads mode MFM and sync word 0x4489.
// A stalled result holds; one more bit waits in the input register, then
// track_stall_o rises.
// ----------------------------------------------------------------------------
module track_bitstream_byte_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          track_valid_i,
  output logic                          track_stall_o,
  input  logic                          track_bit_i,
  input  logic                          track_last_i,
  output logic                          byte_valid_o,
  input  logic                          byte_stall_i,
  output logic [7:0]                    data_byte_o,
  output logic                          short_byte_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbd_pkg::AddrWidth-1:0] paddr,
  input  logic [tbd_pkg::DataWidth-1:0] pwdata,
  output logic [tbd_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);
  import tbd_pkg::*;

  cfg_t    cfg;
  result_t result;

  logic       in_valid_q, in_valid_d;
  logic       in_bit_q, in_last_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_short_q;
  logic       accept;
  logic       step;

  tbd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tbd_decode_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .track_bit_i  (in_bit_q),
    .track_last_i (in_last_q),
    .cfg_i        (cfg),
    .result_o     (result)
  );

  // the held bit moves on whenever the result register is free or draining
  assign step          = in_valid_q && (!out_valid_q || !byte_stall_i);
  assign track_stall_o = in_valid_q && !step;
  assign accept        = track_valid_i && !track_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = result.emit;
    end else if (!byte_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_bit_q  <= track_bit_i;
      in_last_q <= track_last_i;
    end
    if (step && result.emit) begin
      out_byte_q  <= result.data_byte;
      out_short_q <= result.short_byte;
    end
  end

  assign byte_valid_o = out_valid_q;
  assign data_byte_o  = out_byte_q;
  assign short_byte_o = out_short_q;

endmodule
